// File: rtl/rlrq_pkg.sv
package rlrq_pkg;

  // Default sizing
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

  // Fixed widths of the port fields
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned PORT_ID_W  = 8;

  // Most grants that one flush may hand out
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FLUSH_CNT_W = $clog2(MAX_RESULTS);

  localparam logic [INTERVAL_W-1:0] ELAPSED_MAX = '1;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_TICK    = 2'd2,
    OP_FLUSH   = 2'd3
  } opcode_e;

  typedef enum logic {
    KIND_GRANT  = 1'b0,
    KIND_REJECT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_CHECK,
    S_CANCEL,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [PORT_ID_W-1:0] requester_id;
  } in_item_t;

  typedef struct packed {
    logic                 result_kind;
    logic [PORT_ID_W-1:0] granted_id;
    logic                 last;
  } out_item_t;

endpackage

// File: rtl/rlrq_mem.sv
module rlrq_mem #(
  parameter int unsigned DEPTH = rlrq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = rlrq_pkg::ID_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rlrq_ctrl.sv
module rlrq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = rlrq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = rlrq_pkg::ID_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [rlrq_pkg::INTERVAL_W-1:0]      interval_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  rlrq_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rlrq_pkg::out_item_t                  out_data_o,
  output logic                                 mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       mem_waddr_o,
  output logic [ID_BITS-1:0]                   mem_wdata_o,
  output logic                                 mem_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       mem_raddr_o,
  input  logic [ID_BITS-1:0]                   mem_rdata_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FCW   = rlrq_pkg::FLUSH_CNT_W;

  // Circular pointer advance for any depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Stored id onto the 8-bit port field
  function automatic logic [rlrq_pkg::PORT_ID_W-1:0] to_port(input logic [ID_BITS-1:0] v);
    logic [ID_BITS+rlrq_pkg::PORT_ID_W-1:0] ext;
    ext = {{rlrq_pkg::PORT_ID_W{1'b0}}, v};
    return ext[rlrq_pkg::PORT_ID_W-1:0];
  endfunction

  rlrq_pkg::state_e                state_q, state_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [PTR_W-1:0]                head_q, head_d;
  logic [PTR_W-1:0]                tail_q, tail_d;
  logic [rlrq_pkg::INTERVAL_W-1:0] elapsed_q, elapsed_d;
  logic [ID_BITS-1:0]              id_q, id_d;
  rlrq_pkg::kind_e                 kind_q, kind_d;
  logic                            fwd_q, fwd_d;
  logic [PTR_W-1:0]                rp_q, rp_d;
  logic [PTR_W-1:0]                wp_q, wp_d;
  logic [CNT_W-1:0]                left_q, left_d;
  logic                            pend_q, pend_d;
  logic [CNT_W-1:0]                kept_q, kept_d;
  logic [FCW-1:0]                  fn_q, fn_d;
  logic                            out_valid_q, out_valid_d;
  rlrq_pkg::out_item_t             out_q;

  logic                                       accept;
  logic                                       slot_free;
  logic                                       full;
  logic                                       grant_ok;
  logic                                       flush_last;
  rlrq_pkg::opcode_e                          op;
  logic [ID_BITS-1:0]                         id_in;
  logic [ID_BITS+rlrq_pkg::PORT_ID_W-1:0]     in_ext;
  logic                                       emit;
  rlrq_pkg::out_item_t                        emit_data;

  // Decode
  assign op         = rlrq_pkg::opcode_e'(in_data_i.opcode);
  assign in_ext     = {{ID_BITS{1'b0}}, in_data_i.requester_id};
  assign id_in      = in_ext[ID_BITS-1:0];
  assign in_stall_o = (state_q != rlrq_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign grant_ok   = (count_q != '0) && (elapsed_q >= interval_i);
  assign flush_last = (count_q == CNT_W'(1)) || (fn_q == FCW'(rlrq_pkg::MAX_RESULTS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlrq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (op)
            rlrq_pkg::OP_REQUEST: begin
              state_d = ((interval_i == '0) || full) ? rlrq_pkg::S_EMIT : rlrq_pkg::S_CHECK;
            end
            rlrq_pkg::OP_CANCEL: begin
              state_d = (count_q != '0) ? rlrq_pkg::S_CANCEL : rlrq_pkg::S_IDLE;
            end
            rlrq_pkg::OP_TICK: begin
              state_d = rlrq_pkg::S_CHECK;
            end
            rlrq_pkg::OP_FLUSH: begin
              state_d = (count_q != '0) ? rlrq_pkg::S_FLUSH : rlrq_pkg::S_IDLE;
            end
            default: state_d = rlrq_pkg::S_IDLE;
          endcase
        end
      end
      rlrq_pkg::S_EMIT: begin
        if (slot_free) state_d = rlrq_pkg::S_IDLE;
      end
      rlrq_pkg::S_CHECK: begin
        if (!grant_ok || slot_free) state_d = rlrq_pkg::S_IDLE;
      end
      rlrq_pkg::S_CANCEL: begin
        if (!pend_q) state_d = rlrq_pkg::S_IDLE;
      end
      rlrq_pkg::S_FLUSH: begin
        if (slot_free && flush_last) state_d = rlrq_pkg::S_IDLE;
      end
      default: state_d = rlrq_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory requests and result generation
  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    elapsed_d   = elapsed_q;
    id_d        = id_q;
    kind_d      = kind_q;
    fwd_d       = fwd_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    left_d      = left_q;
    pend_d      = pend_q;
    kept_d      = kept_q;
    fn_d        = fn_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = id_in;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    emit        = 1'b0;
    emit_data   = '{result_kind: 1'b0, granted_id: to_port(id_q), last: 1'b1};

    unique case (state_q)
      rlrq_pkg::S_IDLE: begin
        if (accept) begin
          id_d  = id_in;
          fn_d  = '0;
          fwd_d = 1'b0;
          unique case (op)
            rlrq_pkg::OP_REQUEST: begin
              if (interval_i == '0) begin
                kind_d = rlrq_pkg::KIND_GRANT;
              end else if (full) begin
                kind_d = rlrq_pkg::KIND_REJECT;
              end else begin
                // append at the tail, fetch the head for the check
                mem_we_o = 1'b1;
                tail_d   = ptr_inc(tail_q);
                count_d  = count_q + 1'b1;
                fwd_d    = (count_q == '0);
                mem_re_o = 1'b1;
              end
            end
            rlrq_pkg::OP_CANCEL: begin
              if (count_q != '0) begin
                mem_re_o = 1'b1;
                rp_d     = ptr_inc(head_q);
                left_d   = count_q - 1'b1;
                pend_d   = 1'b1;
                wp_d     = head_q;
                kept_d   = '0;
              end
            end
            rlrq_pkg::OP_TICK: begin
              if (elapsed_q != rlrq_pkg::ELAPSED_MAX) elapsed_d = elapsed_q + 1'b1;
              mem_re_o = 1'b1;
            end
            rlrq_pkg::OP_FLUSH: begin
              mem_re_o = 1'b1;
            end
            default: ;
          endcase
        end
      end
      rlrq_pkg::S_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_data = '{result_kind: logic'(kind_q), granted_id: to_port(id_q), last: 1'b1};
        end
      end
      rlrq_pkg::S_CHECK: begin
        // grant the head when the interval has run out
        if (grant_ok && slot_free) begin
          emit      = 1'b1;
          emit_data = '{result_kind: logic'(rlrq_pkg::KIND_GRANT),
                        granted_id: to_port(fwd_q ? id_q : mem_rdata_i), last: 1'b1};
          head_d    = ptr_inc(head_q);
          count_d   = count_q - 1'b1;
          elapsed_d = '0;
        end
      end
      rlrq_pkg::S_CANCEL: begin
        // compaction: keep non-matching entries, written behind the reader
        if (pend_q) begin
          if (mem_rdata_i != id_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = wp_q;
            mem_wdata_o = mem_rdata_i;
            wp_d        = ptr_inc(wp_q);
            kept_d      = kept_q + 1'b1;
          end
          if (left_q != '0) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = rp_q;
            rp_d        = ptr_inc(rp_q);
            left_d      = left_q - 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end else begin
          count_d = kept_q;
          tail_d  = wp_q;
        end
      end
      rlrq_pkg::S_FLUSH: begin
        // one grant per transfer, next head fetched behind it
        if (slot_free) begin
          emit      = 1'b1;
          emit_data = '{result_kind: logic'(rlrq_pkg::KIND_GRANT),
                        granted_id: to_port(mem_rdata_i), last: flush_last};
          head_d    = ptr_inc(head_q);
          count_d   = count_q - 1'b1;
          fn_d      = fn_q + 1'b1;
          if (!flush_last) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = ptr_inc(head_q);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  assign out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlrq_pkg::S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      elapsed_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      elapsed_q   <= elapsed_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    kind_q <= kind_d;
    fwd_q  <= fwd_d;
    rp_q   <= rp_d;
    wp_q   <= wp_d;
    left_q <= left_d;
    kept_q <= kept_d;
    fn_q   <= fn_d;
    if (emit) out_q <= emit_data;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_enqueue_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == rlrq_pkg::OP_REQUEST) && (interval_i != '0) && !full
    |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("accepted request not queued");

  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rlrq_pkg::S_FLUSH) |-> (count_q != '0))
    else $error("flush running on empty queue");

  a_cancel_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rlrq_pkg::S_CANCEL) |-> (kept_q <= count_q))
    else $error("cancel kept more entries than queued");
`endif

endmodule

// File: rtl/rate_limited_request_queue.sv
// Rate-limited request queue: paces grants to requesters.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries an opcode and
// a requester id: request, cancel id, one millisecond tick, or flush.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries grants and
// rejects; last marks the final result of an input item.
// cfg_we_i / cfg_wdata_i write the grant interval in ms (0 = unlimited);
// write it only while the block is idle.
// Queued ids sit in a one-port-write, one-port-read memory with a
// registered read; queue entries are written and read through that memory.
// Request and tick write or read the memory and then check the head; an
// immediate grant or reject goes straight out; cancel reads each queued
// entry once (one entry read per cycle), and flush hands out up to 16
// grants, one per output transfer. A new item is taken only once the
// sequencer is idle again, after the previous one has placed its last
// result, if it has one, in the output register, which is registered.
// Reset clears the queue, elapsed counter and interval; no clearing pass.
// A stall on the output holds the result register and pauses the sequencer
// before its next result; the input then stays stalled.
module rate_limited_request_queue #(
  parameter int unsigned QUEUE_DEPTH = rlrq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = rlrq_pkg::ID_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rlrq_pkg::INTERVAL_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rlrq_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rlrq_pkg::out_item_t             out_data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic [rlrq_pkg::INTERVAL_W-1:0] interval_q;
  logic                            mem_we;
  logic [PTR_W-1:0]                mem_waddr;
  logic [ID_BITS-1:0]              mem_wdata;
  logic                            mem_re;
  logic [PTR_W-1:0]                mem_raddr;
  logic [ID_BITS-1:0]              mem_rdata;

  // Interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  rlrq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .interval_i  (interval_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  rlrq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: test/rlrq_grant_checker.sv
// Watches the configuration port and both channels of the request queue,
// predicts the grants and rejects of every accepted input transfer and
// compares each accepted output transfer with the oldest prediction.
module rlrq_grant_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rlrq_pkg::INTERVAL_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  rlrq_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  rlrq_pkg::out_item_t             out_data_i,
  output int unsigned                     fault_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rlrq_pkg::PORT_ID_W-1:0] ID_MASK =
    rlrq_pkg::PORT_ID_W'((2 ** rlrq_pkg::ID_BITS_DEF) - 1);
  localparam int unsigned REPORT_MAX = 10;

  // Predicted queue state
  logic [rlrq_pkg::PORT_ID_W-1:0]  queued_ids [rlrq_pkg::QUEUE_DEPTH_DEF];
  int unsigned                     queued_count;
  logic [rlrq_pkg::INTERVAL_W-1:0] elapsed_ms;
  logic [rlrq_pkg::INTERVAL_W-1:0] interval_ms;

  rlrq_pkg::out_item_t expected_grants [$];
  int unsigned         fault_count;

  function automatic logic [rlrq_pkg::PORT_ID_W-1:0] pop_head();
    logic [rlrq_pkg::PORT_ID_W-1:0] head;
    head = queued_ids[0];
    for (int unsigned i = 1; i < queued_count; i++) begin
      queued_ids[i-1] = queued_ids[i];
    end
    queued_count--;
    return head;
  endfunction

  task automatic push_grant(input rlrq_pkg::kind_e kind,
                            input logic [rlrq_pkg::PORT_ID_W-1:0] id,
                            input logic fin);
    rlrq_pkg::out_item_t r;
    r.result_kind = kind;
    r.granted_id  = id;
    r.last        = fin;
    expected_grants.push_back(r);
  endtask

  // Grant the head once the interval has elapsed
  task automatic run_update_check();
    if (queued_count > 0 && elapsed_ms >= interval_ms) begin
      push_grant(rlrq_pkg::KIND_GRANT, pop_head(), 1'b1);
      elapsed_ms = '0;
    end
  endtask

  task automatic predict_grants(input rlrq_pkg::in_item_t item);
    logic [rlrq_pkg::PORT_ID_W-1:0] id;
    int unsigned                    kept;
    int unsigned                    n;
    logic                           fin;
    id = item.requester_id & ID_MASK;
    case (item.opcode)
      rlrq_pkg::OP_REQUEST: begin
        if (interval_ms == '0) begin
          push_grant(rlrq_pkg::KIND_GRANT, id, 1'b1);
        end else if (queued_count >= rlrq_pkg::QUEUE_DEPTH_DEF) begin
          push_grant(rlrq_pkg::KIND_REJECT, id, 1'b1);
        end else begin
          queued_ids[queued_count] = id;
          queued_count++;
          run_update_check();
        end
      end
      rlrq_pkg::OP_CANCEL: begin
        // compact the queue, dropping every entry with this id
        kept = 0;
        for (int unsigned i = 0; i < queued_count; i++) begin
          if (queued_ids[i] != id) begin
            queued_ids[kept] = queued_ids[i];
            kept++;
          end
        end
        queued_count = kept;
      end
      rlrq_pkg::OP_TICK: begin
        if (elapsed_ms != rlrq_pkg::ELAPSED_MAX) elapsed_ms++;
        run_update_check();
      end
      rlrq_pkg::OP_FLUSH: begin
        n = 0;
        while (queued_count > 0 && n < rlrq_pkg::MAX_RESULTS) begin
          fin = (queued_count == 1) || (n == rlrq_pkg::MAX_RESULTS - 1);
          push_grant(rlrq_pkg::KIND_GRANT, pop_head(), fin);
          n++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input rlrq_pkg::out_item_t got);
    rlrq_pkg::out_item_t exp;
    if (expected_grants.size() == 0) begin
      if (fault_count < REPORT_MAX) begin
        $display("grant checker: unexpected result kind %0d id %02h last %0d",
                 got.result_kind, got.granted_id, got.last);
      end
      fault_count++;
    end else begin
      exp = expected_grants[0];
      expected_grants.delete(0);
      if (got.result_kind !== exp.result_kind || got.granted_id !== exp.granted_id ||
          got.last !== exp.last) begin
        if (fault_count < REPORT_MAX) begin
          $display({"grant checker: mismatch: expected kind %0d id %02h last %0d,",
                    " got kind %0d id %02h last %0d"},
                   exp.result_kind, exp.granted_id, exp.last,
                   got.result_kind, got.granted_id, got.last);
        end
        fault_count++;
      end
    end
  endtask

  // Sample every transfer at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_count = 0;
      elapsed_ms   = '0;
      interval_ms  = '0;
      expected_grants.delete();
      fault_count  = 0;
      fault_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) interval_ms = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_grants(in_data_i);
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      fault_count_o <= fault_count;
      pending_o     <= expected_grants.size();
    end
  end

endmodule

// File: test/rate_limited_request_queue_tb.sv
// Stimulus and verdict for the rate-limited request queue; checking is done
// by the grant checker beside the block.
module rate_limited_request_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SEG_ITEMS     = 22;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [rlrq_pkg::INTERVAL_W-1:0] cfg_wdata = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  rlrq_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  rlrq_pkg::out_item_t             out_data;

  int unsigned fault_count;
  int unsigned pending_count;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 53;
  int unsigned hold_len      = 0;
  int unsigned hold_left     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rate_limited_request_queue i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rlrq_grant_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .fault_count_o (fault_count),
    .pending_o     (pending_count)
  );

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one transfer and hold it until accepted
  task automatic send_item(input rlrq_pkg::opcode_e op,
                           input logic [rlrq_pkg::PORT_ID_W-1:0] id);
    rlrq_pkg::in_item_t item;
    item.opcode       = op;
    item.requester_id = id;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every predicted result has arrived and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_interval(input logic [rlrq_pkg::INTERVAL_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [rlrq_pkg::INTERVAL_W-1:0] pick_interval();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'd2;
      3, 4:    return rlrq_pkg::INTERVAL_W'($urandom_range(3, 6));
      5:       return rlrq_pkg::INTERVAL_W'($urandom_range(7, 20));
      6:       return '1;
      default: return rlrq_pkg::INTERVAL_W'($urandom);
    endcase
  endfunction

  // Mostly requests and ticks; ids mostly from a small pool so cancels hit
  task automatic random_item();
    int unsigned                    pick;
    rlrq_pkg::opcode_e              op;
    logic [rlrq_pkg::PORT_ID_W-1:0] id;
    pick = $urandom_range(99);
    if (pick < 42)      op = rlrq_pkg::OP_REQUEST;
    else if (pick < 78) op = rlrq_pkg::OP_TICK;
    else if (pick < 92) op = rlrq_pkg::OP_CANCEL;
    else                op = rlrq_pkg::OP_FLUSH;
    if ($urandom_range(3) != 0) id = rlrq_pkg::PORT_ID_W'($urandom_range(7));
    else                        id = rlrq_pkg::PORT_ID_W'($urandom);
    send_item(op, id);
  endtask

  // Give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("rate_limited_request_queue_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unlimited: immediate grants, empty tick, flush and cancel
    send_item(rlrq_pkg::OP_REQUEST, 8'h00);
    send_item(rlrq_pkg::OP_REQUEST, 8'hFF);
    send_item(rlrq_pkg::OP_TICK, 8'hAA);
    send_item(rlrq_pkg::OP_FLUSH, 8'h55);
    send_item(rlrq_pkg::OP_CANCEL, 8'h3C);

    // Longest interval: fill the queue, one reject, cancel duplicates
    set_interval('1);
    for (int unsigned k = 0; k <= rlrq_pkg::QUEUE_DEPTH_DEF; k++) begin
      send_item(rlrq_pkg::OP_REQUEST,
                (k % 4 == 0) ? 8'h5A : rlrq_pkg::PORT_ID_W'(k * 15));
    end
    send_item(rlrq_pkg::OP_CANCEL, 8'h5A);
    send_item(rlrq_pkg::OP_CANCEL, 8'hEE);

    // Back to unlimited with ids still queued
    set_interval('0);
    send_item(rlrq_pkg::OP_REQUEST, 8'hC3);
    send_item(rlrq_pkg::OP_TICK, 8'h00);
    set_interval(16'd1);
    send_item(rlrq_pkg::OP_TICK, 8'h00);
    send_item(rlrq_pkg::OP_FLUSH, 8'h00);
    send_item(rlrq_pkg::OP_FLUSH, 8'h00);

    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 34; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 34; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // empty the queue, then a short queue flushed back to back
          set_interval('0);
          send_item(rlrq_pkg::OP_FLUSH, 8'h00);
          set_interval('1);
          send_item(rlrq_pkg::OP_REQUEST, 8'h77);
          send_item(rlrq_pkg::OP_REQUEST, 8'h78);
          send_item(rlrq_pkg::OP_FLUSH, 8'h00);
        end
      endcase
      for (int unsigned seg = 0; seg < 4; seg++) begin
        set_interval(pick_interval());
        repeat (SEG_ITEMS) random_item();
      end
    end

    // Long receiver hold-off while requests keep coming
    set_interval('0);
    hold_len = HOLD_CYCLES;
    repeat (24) send_item(rlrq_pkg::OP_REQUEST, rlrq_pkg::PORT_ID_W'($urandom));

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("rate_limited_request_queue_tb: PASS");
    end else begin
      $display("rate_limited_request_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rlrq_pkg.sv
rtl/rlrq_mem.sv
rtl/rlrq_ctrl.sv
rtl/rate_limited_request_queue.sv
test/rlrq_grant_checker.sv
test/rate_limited_request_queue_tb.sv
